// ----- design/fcdpll_pkg.sv -----
// shared types, widths and constants for the flux cell dpll
package fcdpll_pkg;

    // field and register widths
    localparam int PERIOD_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int FLUX_W     = 16;
    localparam int INDEX_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN      = CFG_IDX_W'(1);

    // reset values of the registers
    localparam logic [PERIOD_W-1:0] NOMINAL_RESET = PERIOD_W'(20480);
    localparam logic [GAIN_W-1:0]   GAIN_RESET    = GAIN_W'(3277);

    // default parameter values
    localparam int MAX_CELLS_DEF = 32;
    localparam int FRAC_BITS_DEF = 8;

    // item function codes
    localparam logic FUNC_DECODE = 1'b0;
    localparam logic FUNC_RELOCK = 1'b1;

    // divide by five: (x * RECIP5) >> RECIP5_SHIFT is exact for any 32-bit x
    localparam int               MUL_W        = 32;
    localparam logic [MUL_W-1:0] RECIP5       = 32'hCCCC_CCCD;
    localparam int               RECIP5_SHIFT = 34;

    // round half up before dropping the gain fraction
    localparam logic [PERIOD_W+GAIN_W:0] ADJ_ROUND = (PERIOD_W+GAIN_W+1)'(1) << (GAIN_W - 1);

    // largest period value
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    typedef struct packed {
        logic              func;
        logic [FLUX_W-1:0] flux_samples;
    } fcdpll_in_t;

    typedef struct packed {
        logic               bit_value;
        logic               last_cell;
        logic [INDEX_W-1:0] cell_index;
        logic               truncated;
    } fcdpll_out_t;

endpackage

// ----- design/flux_cell_dpll.sv -----
// flux cell dpll top level: sequencer, walk datapath and shared multiplier
//
// Data separator for floppy flux streams. Each input word is a flux interval in
// whole samples (func 0) or a re-lock (func 1). The block walks the interval
// across cell boundaries one boundary per clock and sends one result word per
// cell; the final cell of an interval carries last_cell, and truncated when
// the MAX_CELLS cap cut the walk. After the walk the period is corrected by
// phase * loop_gain and clamped to 0.8 .. 1.2 of nominal, using one shared
// 32x32 multiplier for the phase product and both bounds. A flux word keeps the
// input side busy until its check, walk and period update are done; a re-lock
// leaves it idle. The walk advances only when the output register is free, so
// a stalled result side holds the walk up. The output register lets the last
// cell wait while the next word is taken. Configuration writes are always
// accepted and must only be issued while the block is idle.
module flux_cell_dpll
    import fcdpll_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fcdpll_in_t            s_data,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output fcdpll_out_t           m_data,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int REM_W = FLUX_W + FRAC_BITS;
    localparam int CMP_W = ((REM_W > PERIOD_W) ? REM_W : PERIOD_W) + 2;
    localparam int NC_W  = $clog2(MAX_CELLS + 1);
    localparam int P_W   = PERIOD_W + 2;
    localparam int ADJ_W = PERIOD_W + GAIN_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_ADJ,
        S_LO,
        S_HI,
        S_APPLY
    } state_t;

    state_t                state_reg;
    logic [PERIOD_W-1:0]   nominal_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [PERIOD_W-1:0]   cell_phase_reg;
    logic [PERIOD_W-1:0]   cell_period_reg;
    logic [INDEX_W-1:0]    cell_counter_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [NC_W-1:0]       nc_reg;
    logic [2*MUL_W-1:0]    prod_reg;
    logic [P_W-1:0]        p_reg;
    logic [PERIOD_W-1:0]   lo_reg;
    logic                  m_valid_reg;
    fcdpll_out_t           m_data_reg;

    // walk datapath
    logic [PERIOD_W-1:0]   tb;
    logic [PERIOD_W-1:0]   tb0;
    logic [REM_W-1:0]      rem_next;
    logic                  half_now;
    logic                  reach_now;
    logic                  half_next;
    logic                  reach_next;
    logic                  quarter_next;
    logic                  more_cells;
    logic                  capped;
    logic                  walk_last;
    logic [PERIOD_W-1:0]   phase_fin;
    logic                  out_free;
    logic                  emit;

    // period update datapath
    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [2*MUL_W-1:0]    prod_next;
    logic [ADJ_W-1:0]      adj_sum;
    logic [P_W-1:0]        p_next;
    logic [PERIOD_W:0]     hi_raw;
    logic [PERIOD_W-1:0]   hi_val;
    logic [PERIOD_W-1:0]   period_next;

    // time to the next boundary, saturating when the phase is past the period
    always_comb begin
        tb  = (cell_phase_reg < cell_period_reg) ? cell_period_reg - cell_phase_reg : '0;
        tb0 = cell_period_reg;
        rem_next = rem_reg - REM_W'(tb);
        half_now     = (CMP_W'(rem_reg) << 1) >= CMP_W'(cell_period_reg);
        reach_now    = CMP_W'(rem_reg) >= CMP_W'(tb);
        half_next    = (CMP_W'(rem_next) << 1) >= CMP_W'(cell_period_reg);
        reach_next   = CMP_W'(rem_next) >= CMP_W'(tb0);
        quarter_next = (CMP_W'(rem_next) << 2) < CMP_W'(cell_period_reg);
        more_cells   = half_next && reach_next;
        capped       = (nc_reg == NC_W'(MAX_CELLS - 1));
        walk_last    = !more_cells || capped;
        phase_fin    = (half_next && !reach_next) ? PERIOD_W'(rem_next) : '0;
        out_free     = !m_valid_reg || m_ready;
        emit         = (state_reg == S_WALK) && out_free;
    end

    // shared multiplier operands
    always_comb begin
        unique case (state_reg)
            S_ADJ: begin
                mul_a = MUL_W'(cell_phase_reg);
                mul_b = MUL_W'(gain_reg);
            end
            S_LO: begin
                mul_a = MUL_W'({nominal_reg, 2'b00});
                mul_b = RECIP5;
            end
            S_HI: begin
                mul_a = MUL_W'({nominal_reg, 2'b00}) + MUL_W'({nominal_reg, 1'b0});
                mul_b = RECIP5;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
    end

    // period correction and clamp
    always_comb begin
        adj_sum = ADJ_W'(prod_reg[PERIOD_W+GAIN_W-1:0]) + ADJ_ROUND;
        p_next  = P_W'(cell_period_reg) + P_W'(adj_sum[ADJ_W-1:GAIN_W]);
        hi_raw  = prod_reg[RECIP5_SHIFT +: PERIOD_W+1];
        hi_val  = (hi_raw > (PERIOD_W+1)'(PERIOD_MAX)) ? PERIOD_MAX : hi_raw[PERIOD_W-1:0];
        priority if (p_reg < P_W'(lo_reg)) begin
            period_next = lo_reg;
        end else if (p_reg > P_W'(hi_val)) begin
            period_next = hi_val;
        end else begin
            period_next = p_reg[PERIOD_W-1:0];
        end
    end

    // sequencer, loop state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            nominal_reg      <= NOMINAL_RESET;
            gain_reg         <= GAIN_RESET;
            cell_phase_reg   <= '0;
            cell_period_reg  <= NOMINAL_RESET;
            cell_counter_reg <= '0;
        end else begin
            // configuration writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_NOMINAL_PERIOD: nominal_reg <= cfg_data[PERIOD_W-1:0];
                    REG_LOOP_GAIN:      gain_reg    <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // result word valid: load a new cell or drop the accepted one
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_data.func == FUNC_RELOCK) begin
                            cell_phase_reg   <= '0;
                            cell_period_reg  <= nominal_reg;
                            cell_counter_reg <= '0;
                        end else begin
                            rem_reg   <= REM_W'(s_data.flux_samples) << FRAC_BITS;
                            nc_reg    <= '0;
                            state_reg <= S_CHECK;
                        end
                    end
                end
                // first boundary: cross it, fold the interval into the phase, or drop it when under half a period
                S_CHECK: begin
                    if (half_now && reach_now) begin
                        state_reg <= S_WALK;
                    end else begin
                        if (half_now) begin
                            cell_phase_reg <= cell_phase_reg + PERIOD_W'(rem_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                // one boundary per cycle while the output register is free
                S_WALK: begin
                    if (out_free) begin
                        m_data_reg.bit_value  <= quarter_next;
                        m_data_reg.last_cell  <= walk_last;
                        m_data_reg.cell_index <= cell_counter_reg;
                        m_data_reg.truncated  <= more_cells && capped;
                        cell_counter_reg      <= cell_counter_reg + INDEX_W'(1);
                        nc_reg                <= nc_reg + NC_W'(1);
                        rem_reg               <= rem_next;
                        if (walk_last) begin
                            cell_phase_reg <= phase_fin;
                            state_reg      <= S_ADJ;
                        end else begin
                            cell_phase_reg <= '0;
                        end
                    end
                end
                // phase times gain
                S_ADJ: begin
                    prod_reg  <= prod_next;
                    state_reg <= S_LO;
                end
                // corrected period, low bound product
                S_LO: begin
                    p_reg     <= p_next;
                    prod_reg  <= prod_next;
                    state_reg <= S_HI;
                end
                // low bound, high bound product
                S_HI: begin
                    lo_reg    <= prod_reg[RECIP5_SHIFT +: PERIOD_W];
                    prod_reg  <= prod_next;
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    cell_period_reg <= period_next;
                    state_reg       <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

// ----- design/fcdpll_checker.sv -----
// port-level assertions for the flux cell dpll, bound to the top level
module fcdpll_checker
    import fcdpll_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input fcdpll_in_t            s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input fcdpll_out_t           m_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // truncation is only flagged on the final cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.truncated |-> m_data.last_cell)
        else $error("truncated set on a cell that is not last");

    // no new word is taken while the current interval still has cells to send
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_cell |-> !s_ready)
        else $error("input ready during an unfinished walk");

    // a re-lock leaves the input side ready in the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.func == FUNC_RELOCK) |=> s_ready)
        else $error("re-lock did not return to idle");

endmodule

bind flux_cell_dpll fcdpll_checker u_fcdpll_checker (.*);

// ----- tb/tb_flux_cell_dpll.sv -----
// self-checking testbench for the flux cell dpll: scoreboard class, word drivers, phases
module tb_flux_cell_dpll;
    import fcdpll_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_WORDS   = 36;
    localparam int PHASE_COUNT   = 7;

    // predicts the cell words of each accepted flux word and checks them in order
    class cell_scoreboard;
        logic [PERIOD_W-1:0] nominal;
        logic [GAIN_W-1:0]   gain;
        logic [PERIOD_W-1:0] phase;
        logic [PERIOD_W-1:0] period;
        logic [INDEX_W-1:0]  counter;
        fcdpll_out_t         expected_cells[$];
        int                  mismatches;

        function new();
            nominal    = NOMINAL_RESET;
            gain       = GAIN_RESET;
            mismatches = 0;
            relock();
        endfunction

        function void relock();
            phase   = '0;
            period  = nominal;
            counter = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_NOMINAL_PERIOD) nominal = data[PERIOD_W-1:0];
            else if (idx == REG_LOOP_GAIN) gain = data[GAIN_W-1:0];
        endfunction

        // period plus rounded phase correction, clamped to 0.8 .. 1.2 of nominal
        function logic [PERIOD_W-1:0] corrected(longint unsigned per, longint unsigned ph);
            longint unsigned p, lo, hi, nom;
            nom = nominal;
            p   = per + ((ph * longint'(gain) + longint'(ADJ_ROUND)) >> GAIN_W);
            lo  = (nom * 4) / 5;
            hi  = (nom * 6) / 5;
            if (hi > longint'(PERIOD_MAX)) hi = PERIOD_MAX;
            if (p < lo) p = lo;
            if (p > hi) p = hi;
            return p[PERIOD_W-1:0];
        endfunction

        // walk the interval across cell boundaries
        function void take_word(fcdpll_in_t w);
            longint unsigned rem, per, ph, tb;
            int              n;
            bit              cut;
            fcdpll_out_t     c;
            if (w.func == FUNC_RELOCK) begin
                relock();
                return;
            end
            rem = longint'(w.flux_samples) << FRAC_BITS_DEF;
            per = period;
            ph  = phase;
            n   = 0;
            cut = 1'b0;
            while (2 * rem >= per) begin
                tb = (ph < per) ? per - ph : 0;
                if (rem < tb) begin
                    ph = ph + rem;
                    break;
                end
                if (n >= MAX_CELLS_DEF) begin
                    cut = 1'b1;
                    break;
                end
                rem           = rem - tb;
                ph            = 0;
                c.bit_value   = (4 * rem < per);
                c.last_cell   = 1'b0;
                c.cell_index  = counter;
                c.truncated   = 1'b0;
                expected_cells.push_back(c);
                counter       = counter + 1;
                n++;
            end
            phase = ph[PERIOD_W-1:0];
            if (n > 0) begin
                c           = expected_cells.pop_back();
                c.last_cell = 1'b1;
                c.truncated = cut;
                expected_cells.push_back(c);
                period      = corrected(per, longint'(phase));
            end
        endfunction

        function void check_cell(fcdpll_out_t got);
            fcdpll_out_t want;
            if (expected_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected cell word: bit %0d last %0d index %0d trunc %0d",
                             got.bit_value, got.last_cell, got.cell_index, got.truncated);
                return;
            end
            want = expected_cells.pop_front();
            if (got.bit_value !== want.bit_value || got.last_cell !== want.last_cell ||
                got.cell_index !== want.cell_index || got.truncated !== want.truncated) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $write("cell %0d wrong: expected bit %0d last %0d index %0d trunc %0d, ",
                           want.cell_index, want.bit_value, want.last_cell, want.cell_index,
                           want.truncated);
                    $display("got bit %0b last %0b index %0d trunc %0b",
                             got.bit_value, got.last_cell, got.cell_index, got.truncated);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    fcdpll_in_t            s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    fcdpll_out_t           m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    cell_scoreboard tracker = new();
    bit             burst_mode = 1'b0;

    flux_cell_dpll DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic fcdpll_in_t make_word(logic f, int unsigned flux);
        fcdpll_in_t w;
        w.func         = f;
        w.flux_samples = flux[FLUX_W-1:0];
        return w;
    endfunction

    // mostly 1..4 cells of the nominal period with jitter, plus raw noise
    function automatic int unsigned pick_interval();
        int unsigned cell_s, sel;
        longint      v;
        cell_s = tracker.nominal >> FRAC_BITS_DEF;
        sel    = $urandom_range(0, 9);
        if (sel < 7 && cell_s > 0) begin
            v = longint'(cell_s) * $urandom_range(1, 4)
                + longint'($urandom_range(0, cell_s / 4)) - longint'(cell_s / 8);
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
        end else if (sel == 7) begin
            v = $urandom_range(0, 65535);
        end else if (sel == 8) begin
            v = $urandom_range(0, 3);
        end else begin
            v = $urandom_range(0, 255);
        end
        return 32'(v);
    endfunction

    // send one input word after a random gap (no gap in burst mode)
    task automatic send_word(input fcdpll_in_t w);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        tracker.take_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop input, drain every expected cell, then let the period update finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.expected_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random stall before each word (no stall in burst mode)
    initial begin : result_side
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = burst_mode ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_cell(m_data);
        end
    end

    initial begin : main
        int unsigned         first_run[] = '{0, 1, 40, 80, 20, 160, 240, 320, 65535};
        logic [PERIOD_W-1:0] nom;
        logic [GAIN_W-1:0]   gn;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, half and quarter edges, cap
        send_word(make_word(FUNC_RELOCK, 16'hFFFF));
        foreach (first_run[i]) send_word(make_word(FUNC_DECODE, first_run[i]));
        send_word(make_word(FUNC_RELOCK, 0));
        send_word(make_word(FUNC_DECODE, 79));
        send_word(make_word(FUNC_DECODE, 81));
        wait_idle();

        // small nominal of 512 without re-lock: phase ends up beyond the period
        write_reg(REG_NOMINAL_PERIOD, {8'hA5, 24'd512});
        send_word(make_word(FUNC_DECODE, 150));
        send_word(make_word(FUNC_DECODE, 10));
        send_word(make_word(FUNC_DECODE, 3));
        wait_idle();

        // zero gain
        write_reg(REG_LOOP_GAIN, 32'hFFFF_0000);
        send_word(make_word(FUNC_RELOCK, 0));
        send_word(make_word(FUNC_DECODE, 2));
        send_word(make_word(FUNC_DECODE, 7));
        wait_idle();

        // largest nominal and gain
        write_reg(REG_NOMINAL_PERIOD, 32'h00FF_FFFF);
        write_reg(REG_LOOP_GAIN, 32'h0000_FFFF);
        send_word(make_word(FUNC_RELOCK, 0));
        send_word(make_word(FUNC_DECODE, 65535));
        send_word(make_word(FUNC_DECODE, 0));
        wait_idle();

        // zero period: every interval hits the cap
        write_reg(REG_NOMINAL_PERIOD, 32'h5A00_0000);
        write_reg(CFG_IDX_W'(2), 32'h1234_5678);
        write_reg(CFG_IDX_W'(255), 32'hFFFF_FFFF);
        send_word(make_word(FUNC_RELOCK, 0));
        send_word(make_word(FUNC_DECODE, 0));
        wait_idle();

        // random phases over several settings
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin nom = NOMINAL_RESET; gn = GAIN_RESET; end
                1: begin nom = 24'd512; gn = '0; end
                2: begin nom = PERIOD_MAX; gn = '1; end
                3: begin
                    nom = PERIOD_W'($urandom_range(512, 40000));
                    gn  = GAIN_W'($urandom_range(0, 65535));
                end
                4: begin
                    nom = PERIOD_W'($urandom_range(0, 511));
                    gn  = GAIN_W'($urandom_range(0, 65535));
                end
                5: begin nom = PERIOD_W'($urandom_range(512, 24'hFF_FFFF)); gn = '1; end
                default: begin
                    nom = PERIOD_W'($urandom_range(2000, 30000));
                    gn  = GAIN_W'($urandom_range(0, 65535));
                end
            endcase
            burst_mode = (p % 3 == 2);
            write_reg(REG_NOMINAL_PERIOD, {8'($urandom), nom});
            write_reg(REG_LOOP_GAIN, {16'($urandom), gn});
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
            if ($urandom_range(0, 3) != 0)
                send_word(make_word(FUNC_RELOCK, $urandom_range(0, 65535)));
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_word(make_word(FUNC_RELOCK, $urandom_range(0, 65535)));
                else
                    send_word(make_word(FUNC_DECODE, pick_interval()));
            end
            wait_idle();
        end

        if (tracker.mismatches == 0 && tracker.expected_cells.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
